[rtl/lag_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lag_pkg: shared definitions for the life automaton grid
// Operation codes, the default grid size and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int GRID_SIZE_DEF = 64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [3:0] SURVIVE_CNT = 4'd2;
  localparam logic [3:0] BIRTH_CNT   = 4'd3;

  // next state of one cell from its 3x3 window (bit 1 of cur is the cell)
  function automatic logic cell_next(input logic [2:0] above, input logic [2:0] cur,
                                     input logic [2:0] below);
    logic [3:0] n;
    n = 4'($countones({above, cur[2], cur[0], below}));
    return (n == BIRTH_CNT) || (cur[1] && (n == SURVIVE_CNT));
  endfunction

endpackage
`default_nettype wire

[rtl/life_automaton_grid_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_grid_top: bounded B3/S23 life grid with cell access
// Writes or reads single cells and advances the whole grid one generation,
// one row per cycle through a shared row update unit.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  in      | in_valid / in_stall  | op, col, row, alive_in
//  out     | out_valid / out_stall| alive_out, step_done
//
//  A read or write goes through one registered row read, then the result
//  (a write does read-modify-write of the row word). The unused op code and
//  positions off the grid skip the row read and go straight to the result.
//  A step primes two rows, then runs the row unit once per row, reading two
//  rows ahead.
//  One item is in work at a time; in_stall is high until its result is
//  loaded into the output register, which waits on out_stall if it is full.
//  Reset clears the per-row valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module life_automaton_grid_top #(
  parameter int GRID_SIZE = lag_pkg::GRID_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op,
  input  wire logic [5:0] col,
  input  wire logic [5:0] row,
  input  wire logic       alive_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            alive_out,
  output logic            step_done
);
  import lag_pkg::*;

  localparam int ADDR_W = $clog2(GRID_SIZE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]           state;
  logic [1:0]           op_q;
  logic [ADDR_W-1:0]    col_q;
  logic [ADDR_W-1:0]    row_q;
  logic                 val_q;
  logic [ADDR_W-1:0]    scan;
  logic [GRID_SIZE-1:0] above;
  logic [GRID_SIZE-1:0] cur;
  logic                 res_alive;
  logic                 res_done;

  logic                 accept;
  logic                 in_grid;
  logic                 last_row;
  logic [ADDR_W:0]      ahead;
  logic [GRID_SIZE-1:0] below;
  logic [GRID_SIZE-1:0] row_next;
  logic [GRID_SIZE-1:0] bit_mask;
  logic                 out_free;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [GRID_SIZE-1:0] wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [GRID_SIZE-1:0] rd_data;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_grid  = (7'(col) < 7'(GRID_SIZE)) && (7'(row) < 7'(GRID_SIZE));
  assign last_row = (scan == ADDR_W'(GRID_SIZE - 1));
  assign ahead    = {1'b0, scan} + (ADDR_W + 1)'(2);
  assign below    = last_row ? '0 : rd_data;
  assign bit_mask = GRID_SIZE'(1) << col_q;
  assign out_free = !out_valid || !out_stall;

  lag_grid_mem #(
    .DEPTH (GRID_SIZE),
    .WIDTH (GRID_SIZE),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lag_row_unit #(
    .WIDTH(GRID_SIZE)
  ) u_row (
    .above(above),
    .cur  (cur),
    .below(below),
    .nxt  (row_next)
  );

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan;
    wr_data = row_next;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rd_en   = (op == OP_STEP) || ((op inside {OP_READ, OP_WRITE}) && in_grid);
          rd_addr = (op == OP_STEP) ? '0 : ADDR_W'(row);
        end
      end
      S_RMW: begin
        wr_en   = (op_q == OP_WRITE);
        wr_addr = row_q;
        wr_data = (rd_data & ~bit_mask) | ({GRID_SIZE{val_q}} & bit_mask);
      end
      S_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(1);
      end
      S_RUN: begin
        wr_en   = 1'b1;
        // fetch two rows ahead; past the bottom edge nothing is read
        rd_en   = (ahead < (ADDR_W + 1)'(GRID_SIZE));
        rd_addr = ahead[ADDR_W-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_STEP) begin
              state <= S_LOAD;
            end else if ((op inside {OP_READ, OP_WRITE}) && in_grid) begin
              state <= S_RMW;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_RMW: begin
          state <= S_RESP;
        end
        S_LOAD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (last_row) begin
            scan  <= '0;
            state <= S_RESP;
          end else begin
            scan <= scan + ADDR_W'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item fields, row window and pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q      <= op;
          col_q     <= ADDR_W'(col);
          row_q     <= ADDR_W'(row);
          val_q     <= alive_in;
          res_alive <= 1'b0;
          res_done  <= (op == OP_STEP);
          above     <= '0;
        end
      end
      S_RMW: begin
        res_alive <= (op_q == OP_READ) && rd_data[col_q];
      end
      S_LOAD: begin
        cur <= rd_data;
      end
      S_RUN: begin
        above <= cur;
        cur   <= below;
      end
      default: begin
        res_alive <= res_alive;
      end
    endcase
  end

  // output register: load on the final state, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      alive_out <= res_alive;
      step_done <= res_done;
    end
  end

endmodule
`default_nettype wire

[rtl/lag_row_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lag_row_unit: next generation of one grid row
// Applies the cell rule to every column of a row in parallel, from the old
// rows above, at and below it. Columns past either edge count as dead.
// ----------------------------------------------------------------------------
module lag_row_unit #(
  parameter int WIDTH = lag_pkg::GRID_SIZE_DEF
) (
  input  wire logic [WIDTH-1:0] above,
  input  wire logic [WIDTH-1:0] cur,
  input  wire logic [WIDTH-1:0] below,
  output logic      [WIDTH-1:0] nxt
);
  import lag_pkg::*;

  logic [WIDTH+1:0] above_pad;
  logic [WIDTH+1:0] cur_pad;
  logic [WIDTH+1:0] below_pad;

  // pad with a dead column on each side for the hard edges
  assign above_pad = {1'b0, above, 1'b0};
  assign cur_pad   = {1'b0, cur, 1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  for (genvar x = 0; x < WIDTH; x++) begin : g_col
    assign nxt[x] = cell_next(above_pad[x+2:x], cur_pad[x+2:x], below_pad[x+2:x]);
  end

endmodule
`default_nettype wire

[rtl/lag_grid_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lag_grid_mem: row store of the grid
// One word per row, one write and one registered read port. A per-row valid
// bit, cleared at reset, makes unwritten rows read as all dead.
// ----------------------------------------------------------------------------
module lag_grid_mem #(
  parameter int DEPTH  = lag_pkg::GRID_SIZE_DEF,
  parameter int WIDTH  = lag_pkg::GRID_SIZE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [WIDTH-1:0] mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule
`default_nettype wire
